// ----- rtl/lzssd_pkg.sv -----
// Shared constants and types for the LZSS stream decoder.
// No dependencies; imported by lzssd_window, lzss_stream_decoder and its testbench.

package lzssd_pkg;

   localparam int WIN_DEPTH = 4096;
   localparam int WIN_AW    = $clog2(WIN_DEPTH);
   localparam int MIN_MATCH = 3;
   localparam int LEN_W     = 9;
   localparam int OUT_BYTES = 8;

   // Parse phases of the token decoder.
   localparam logic [1:0] PH_TOKEN  = 2'd0;
   localparam logic [1:0] PH_OFF_HI = 2'd1;
   localparam logic [1:0] PH_OFF_LO = 2'd2;
   localparam logic [1:0] PH_COPY   = 2'd3;

   typedef logic [WIN_AW-1:0] win_addr_type;

   // Request from the decoder to the history window for one cycle.
   typedef struct packed {
      logic         app_en;
      logic [7:0]   app_byte;
      logic         rd_en;
      win_addr_type rd_addr;
   } win_req_type;

endpackage

// ----- rtl/lzssd_window.sv -----
// History window of the LZSS stream decoder: ring memory with append and read ports.
// Depends on lzssd_pkg for the window size and the request struct.

module lzssd_window
   import lzssd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  win_req_type  win_req,
   output logic [7:0]   rd_byte,
   output win_addr_type win_start
);

   logic [7:0]   mem [WIN_DEPTH];
   logic [7:0]   q_ff;
   logic         zero_ff, zero_in;
   logic         fwd_ff, fwd_in;
   logic [7:0]   fwd_byte_ff;
   win_addr_type start_ff, start_in;
   win_addr_type end_ff, end_in;
   logic         wrapped_ff, wrapped_in;

   // Entries not yet written since reset read as zero; until the first wrap these
   // are exactly the ones at or above the end pointer. A read of the entry being
   // appended in the same cycle takes the new byte from the forwarding path.
   always_comb begin
      end_in     = end_ff;
      start_in   = start_ff;
      wrapped_in = wrapped_ff;
      if (win_req.app_en) begin
         end_in = end_ff + 1'b1;
         if (end_ff == '1) begin
            wrapped_in = 1'b1;
         end
         if (end_in == start_ff) begin
            start_in = start_ff + 1'b1;
         end
      end
      zero_in = !(wrapped_ff || (win_req.rd_addr < end_ff));
      fwd_in  = win_req.rd_en && win_req.app_en && (win_req.rd_addr == end_ff);
   end

   always_ff @(posedge clock) begin
      if (win_req.app_en) begin
         mem[end_ff] <= win_req.app_byte;
      end
      if (win_req.rd_en) begin
         q_ff        <= mem[win_req.rd_addr];
         zero_ff     <= zero_in;
         fwd_ff      <= fwd_in;
         fwd_byte_ff <= win_req.app_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         end_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         start_ff   <= start_in;
         end_ff     <= end_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign rd_byte   = fwd_ff ? fwd_byte_ff : (zero_ff ? 8'h00 : q_ff);
   assign win_start = start_ff;

`ifndef ASSERT_OFF
   a_start_before_wrap: assert property (@(posedge clock) disable iff (reset)
      !wrapped_ff |-> start_ff == '0)
      else $error("window start moved before the window filled");

   a_start_after_wrap: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |-> start_ff == win_addr_type'(end_ff + 1'b1))
      else $error("full window start does not follow the end pointer");

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      win_req.rd_en && win_req.app_en && win_req.rd_addr == end_ff
      |=> rd_byte == $past(win_req.app_byte))
      else $error("read of the entry being appended missed the new byte");
`endif

endmodule

// ----- rtl/lzss_stream_decoder.sv -----
// LZSS stream decoder top level: token parser, match copy sequencer and output packer.
// Depends on lzssd_pkg and lzssd_window.

// Compressed bytes enter one per transfer and decoded bytes leave packed up to eight per
// transfer, first byte in bits 7:0. Flag, length and offset bytes and literals are each
// taken in one transfer, and every input byte needs the output register free. After the
// offset low byte the input stalls while the match is copied: one window byte per cycle
// while the output is not stalled, as the single read and single append port of the
// 4096-byte window allow; a full output word waiting on a stalled consumer holds the copy.
// No clearing pass follows reset: entries never written read as zero through the window's
// fill tracking, so the block is ready in the first cycle after reset.

module lzss_stream_decoder
   import lzssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last
);

   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       flag_ff, flag_in;
   logic [3:0]       bits_left_ff, bits_left_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       off_hi_ff, off_hi_in;

   win_addr_type     rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0] rd_left_ff, rd_left_in;
   logic             ret_valid_ff, ret_valid_in;
   logic             ret_fin_ff, ret_fin_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [7:0]       skid_byte_ff, skid_byte_in;
   logic             skid_fin_ff, skid_fin_in;
   logic [63:0]      acc_ff, acc_in;
   logic [2:0]       fill_ff, fill_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_bytes_ff, rsp_bytes_in;
   logic [3:0]       rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;

   win_req_type      win_req;
   logic [7:0]       rd_byte;
   win_addr_type     win_start;

   logic             out_free;
   logic             req_take;
   logic             src_valid;
   logic [7:0]       src_byte;
   logic             src_fin;
   logic             flush;
   logic             absorb;
   logic             issue;
   logic [3:0]       bits_dec;
   logic [15:0]      off_full;
   logic [63:0]      packed_bytes;

   lzssd_window u_window (
      .clock     (clock),
      .reset     (reset),
      .win_req   (win_req),
      .rd_byte   (rd_byte),
      .win_start (win_start)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (phase_ff == PH_COPY) || !out_free;
      req_take  = req_valid && !req_stall;

      // A byte held in the skid stage always precedes any byte still in the read path.
      src_valid = skid_valid_ff || ret_valid_ff;
      src_byte  = skid_valid_ff ? skid_byte_ff : rd_byte;
      src_fin   = skid_valid_ff ? skid_fin_ff : ret_fin_ff;
      flush     = src_valid && ((fill_ff == 3'd7) || src_fin);
      absorb    = src_valid && (!flush || out_free);
      issue     = (phase_ff == PH_COPY) && (rd_left_ff != '0) && !skid_valid_ff
                  && !(ret_valid_ff && !absorb);

      packed_bytes = acc_ff | (64'(src_byte) << {fill_ff, 3'b000});
      bits_dec     = bits_left_ff - 4'd1;
      off_full     = {off_hi_ff, req_in_byte};

      phase_in      = phase_ff;
      flag_in       = flag_ff;
      bits_left_in  = bits_left_ff;
      len_in        = len_ff;
      off_hi_in     = off_hi_ff;
      rd_addr_in    = rd_addr_ff;
      rd_left_in    = rd_left_ff;
      ret_valid_in  = issue;
      ret_fin_in    = (rd_left_ff == LEN_W'(1));
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      skid_fin_in   = skid_fin_ff;
      acc_in        = acc_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      win_req.app_en   = ret_valid_ff;
      win_req.app_byte = ret_valid_ff ? rd_byte : req_in_byte;
      win_req.rd_en    = issue;
      win_req.rd_addr  = rd_addr_ff;

      if (req_take) begin
         case (phase_ff)
            PH_OFF_HI: begin
               off_hi_in = req_in_byte;
               phase_in  = PH_OFF_LO;
            end
            PH_OFF_LO: begin
               rd_addr_in = win_start + off_full[WIN_AW-1:0];
               rd_left_in = len_ff;
               phase_in   = PH_COPY;
            end
            default: begin
               phase_in = PH_TOKEN;
               if (bits_left_ff == 4'd0) begin
                  flag_in      = req_in_byte;
                  bits_left_in = 4'd8;
               end else begin
                  bits_left_in = bits_dec;
                  if (flag_ff[bits_dec[2:0]]) begin
                     len_in   = LEN_W'(req_in_byte) + LEN_W'(MIN_MATCH);
                     phase_in = PH_OFF_HI;
                  end else begin
                     win_req.app_en = 1'b1;
                     rsp_valid_in   = 1'b1;
                     rsp_bytes_in   = 64'(req_in_byte);
                     rsp_count_in   = 4'd1;
                     rsp_last_in    = 1'b1;
                  end
               end
            end
         endcase
      end

      if (issue) begin
         rd_addr_in = rd_addr_ff + 1'b1;
         rd_left_in = rd_left_ff - 1'b1;
      end

      if (ret_valid_ff && !absorb) begin
         skid_valid_in = 1'b1;
         skid_byte_in  = rd_byte;
         skid_fin_in   = ret_fin_ff;
      end else if (skid_valid_ff && absorb) begin
         skid_valid_in = 1'b0;
      end

      if (absorb) begin
         if (flush) begin
            rsp_valid_in = 1'b1;
            rsp_bytes_in = packed_bytes;
            rsp_count_in = {1'b0, fill_ff} + 4'd1;
            rsp_last_in  = src_fin;
            acc_in       = '0;
            fill_in      = 3'd0;
            if (src_fin) begin
               phase_in = PH_TOKEN;
            end
         end else begin
            acc_in  = packed_bytes;
            fill_in = fill_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TOKEN;
         flag_ff       <= '0;
         bits_left_ff  <= '0;
         len_ff        <= '0;
         off_hi_ff     <= '0;
         rd_left_ff    <= '0;
         ret_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         acc_ff        <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         flag_ff       <= flag_in;
         bits_left_ff  <= bits_left_in;
         len_ff        <= len_in;
         off_hi_ff     <= off_hi_in;
         rd_left_ff    <= rd_left_in;
         ret_valid_ff  <= ret_valid_in;
         skid_valid_ff <= skid_valid_in;
         acc_ff        <= acc_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      ret_fin_ff   <= ret_fin_in;
      skid_byte_ff <= skid_byte_in;
      skid_fin_ff  <= skid_fin_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_bytes  = rsp_bytes_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef ASSERT_OFF
   a_skid_excl: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !ret_valid_ff)
      else $error("skid stage and read path hold bytes at once");

   a_idle_copy: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_COPY |-> !ret_valid_ff && !skid_valid_ff && fill_ff == 3'd0)
      else $error("copy state left with bytes still in flight");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff != 4'd0 && rsp_count_ff <= 4'd8)
      else $error("result byte count out of range");

   a_copy_done: assert property (@(posedge clock) disable iff (reset)
      absorb && src_fin |=> phase_ff == PH_TOKEN && rsp_valid_ff && rsp_last_ff)
      else $error("final copied byte did not close the match");
`endif

endmodule

// ----- verif/lzss_stream_decoder_test.sv -----
// Self-checking testbench for lzss_stream_decoder: drives compressed byte streams and checks
// every packed output transfer against a predictor kept in a small scoreboard class.
// Depends on lzssd_pkg and the lzss_stream_decoder RTL.

module lzss_stream_decoder_test
   import lzssd_pkg::*;
();

   localparam int MAX_WAIT     = 13;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 64;

   class lzss_decode_scoreboard;
      logic [7:0]       hist [WIN_DEPTH];
      win_addr_type     head;
      win_addr_type     tail;
      logic [7:0]       flags;
      logic [3:0]       flags_left;
      logic [1:0]       phase;
      logic [LEN_W-1:0] copy_len;
      logic [7:0]       off_hi;
      logic [63:0]      acc;
      int               acc_n;
      logic [63:0]      want_bytes [$];
      logic [3:0]       want_count [$];
      logic             want_last [$];
      int               errors;

      function new();
         foreach (hist[i]) hist[i] = 8'h00;
         head = '0;
         tail = '0;
         flags = 8'h00;
         flags_left = 4'd0;
         phase = PH_TOKEN;
         copy_len = '0;
         off_hi = 8'h00;
         acc = '0;
         acc_n = 0;
         errors = 0;
      endfunction

      function win_addr_type fill();
         return tail - head;
      endfunction

      function int pending();
         return want_bytes.size();
      endfunction

      function void append(logic [7:0] c);
         hist[tail] = c;
         tail = tail + 1'b1;
         // A full window drops its oldest byte.
         if (tail == head) head = head + 1'b1;
      endfunction

      function void push_packet(int n);
         want_bytes.push_back(acc);
         want_count.push_back(4'(n));
         want_last.push_back(1'b0);
         acc = '0;
         acc_n = 0;
      endfunction

      function int pack_byte(logic [7:0] c);
         acc[8*acc_n +: 8] = c;
         acc_n++;
         if (acc_n == OUT_BYTES) begin
            push_packet(OUT_BYTES);
            return 1;
         end
         return 0;
      endfunction

      function int flush_pack();
         if (acc_n != 0) begin
            push_packet(acc_n);
            return 1;
         end
         return 0;
      endfunction

      // Advances the decoder state by one accepted input byte and queues its packets.
      function void take_token(logic [7:0] b);
         logic [15:0]  off;
         win_addr_type addr;
         logic [7:0]   c;
         int           made;
         int           j;
         made = 0;
         case (phase)
            PH_OFF_HI: begin
               off_hi = b;
               phase = PH_OFF_LO;
            end
            PH_OFF_LO: begin
               off = {off_hi, b};
               addr = head + win_addr_type'(off);
               for (j = 0; j < int'(copy_len); j++) begin
                  c = hist[addr];
                  made += pack_byte(c);
                  append(c);
                  addr = addr + 1'b1;
               end
               made += flush_pack();
               if (made > 0) want_last[want_last.size()-1] = 1'b1;
               phase = PH_TOKEN;
            end
            default: begin
               phase = PH_TOKEN;
               if (flags_left == 4'd0) begin
                  flags = b;
                  flags_left = 4'd8;
               end else begin
                  flags_left = flags_left - 1'b1;
                  if (flags[flags_left[2:0]]) begin
                     copy_len = LEN_W'(b) + LEN_W'(MIN_MATCH);
                     phase = PH_OFF_HI;
                  end else begin
                     made = pack_byte(b);
                     append(b);
                     made += flush_pack();
                     want_last[want_last.size()-1] = 1'b1;
                  end
               end
            end
         endcase
      endfunction

      function void check_packet(logic [63:0] data, logic [3:0] count, logic is_last);
         logic [63:0] e_data;
         logic [3:0]  e_count;
         logic        e_last;
         if (want_bytes.size() == 0) begin
            $display("%0t: unexpected result: expected none, got out_bytes %h count %0d last %b",
                     $time, data, count, is_last);
            errors++;
            return;
         end
         e_data = want_bytes.pop_front();
         e_count = want_count.pop_front();
         e_last = want_last.pop_front();
         if (data !== e_data) begin
            $display("%0t: out_bytes expected %h got %h", $time, e_data, data);
            errors++;
         end
         if (count !== e_count) begin
            $display("%0t: byte_count expected %0d got %0d", $time, e_count, count);
            errors++;
         end
         if (is_last !== e_last) begin
            $display("%0t: last expected %b got %b", $time, e_last, is_last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_out_bytes;
   logic [3:0]  rsp_byte_count;
   logic        rsp_last;

   lzss_decode_scoreboard board = new();
   bit fast_mode = 1'b0;
   bit hold_rsp = 1'b0;
   int sent = 0;
   int cycles = 0;

   lzss_stream_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_bytes  (rsp_out_bytes),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last       (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL lzss_stream_decoder");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge; results are checked before new input
   // is noted, as a result never stems from a byte accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_packet(rsp_out_bytes, rsp_byte_count, rsp_last);
         if (req_valid && !req_stall) board.take_token(req_in_byte);
      end
   end

   function automatic int draw_wait();
      if (fast_mode) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Receiver: random stall before each transfer, plus one long hold-off on request.
   initial begin
      int n;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         n = draw_wait();
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_byte = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_match(input logic [7:0] len_byte, input logic [15:0] off);
      send_byte(len_byte);
      send_byte(off[15:8]);
      send_byte(off[7:0]);
   endtask

   function automatic logic [7:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 8'd255;
      if (r < 15) return 8'($urandom_range(13, 80));
      return 8'($urandom_range(0, 12));
   endfunction

   // Mostly short back references so that copies overlap recent output.
   function automatic logic [15:0] pick_offset();
      int r;
      int level;
      int reach;
      r = $urandom_range(0, 99);
      level = int'(board.fill());
      if (level > 0 && r < 60) begin
         reach = (level < 64) ? level : 64;
         return 16'(level - $urandom_range(1, reach));
      end
      if (level > 0 && r < 80) return 16'($urandom_range(0, level - 1));
      return 16'($urandom_range(0, 65535));
   endfunction

   // Finishes whatever token the decoder is part way through, so a new group starts cleanly.
   task automatic realign();
      while (!(board.phase == PH_TOKEN && board.flags_left == 4'd0)) begin
         if (board.phase != PH_TOKEN) send_byte(8'($urandom_range(0, 255)));
         else if (board.flags[board.flags_left[2:0] - 3'd1]) send_byte(8'($urandom_range(0, 12)));
         else send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_group();
      logic [7:0] flag_byte;
      int i;
      flag_byte = 8'($urandom_range(0, 255));
      send_byte(flag_byte);
      for (i = 7; i >= 0; i--) begin
         if (flag_byte[i]) send_match(pick_length(), pick_offset());
         else send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic random_stream(input int count);
      int target;
      target = sent + count;
      while (sent < target) begin
         if ($urandom_range(0, 7) == 0) fast_mode = !fast_mode;
         if ($urandom_range(0, 99) < 15) begin
            // Stray bytes break the group structure on purpose.
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            realign();
            send_group();
         end
      end
      fast_mode = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Eight literals covering the byte extremes.
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h7F);
      send_byte(8'hFE);
      // Mixed group: longest match from beyond the window over unwritten bytes, shortest
      // match from the oldest byte, an overlapping repeat and an offset past the window.
      send_byte(8'hA5);
      send_match(8'd255, 16'hFFFF);
      send_byte(8'h3C);
      send_match(8'd0, 16'h0000);
      send_byte(8'hC3);
      send_byte(8'h0F);
      send_match(8'd5, 16'(board.fill() - 1'b1));
      send_byte(8'hF0);
      send_match(8'd10, 16'h8003);
      drain();

      // Hold the receiver off while literals keep coming, so the input backs up.
      hold_rsp = 1'b1;
      fast_mode = 1'b1;
      repeat (2) begin
         send_byte(8'h00);
         repeat (8) send_byte(8'($urandom_range(0, 255)));
      end
      fast_mode = 1'b0;
      drain();

      random_stream(RANDOM_ITEMS / 2);

      // Long copies until the window has wrapped and its start pointer moves.
      realign();
      fast_mode = 1'b1;
      repeat (2) begin
         send_byte(8'hFF);
         repeat (8) send_match(8'd255, pick_offset());
      end
      fast_mode = 1'b0;

      random_stream(RANDOM_ITEMS - RANDOM_ITEMS / 2);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASS lzss_stream_decoder");
      end else begin
         $display("FAIL lzss_stream_decoder");
      end
      $finish;
   end

endmodule
